/* src/svfb_pkg.sv */
// Shared types, constants and the digit decoder for the seven-segment frame builder.
`timescale 1ns / 1ps

package svfb_pkg;

  // Input word: one show or clear request
  typedef struct packed {
    logic               action;
    logic signed [15:0] value_tenths;
    logic [1:0]         display_select;
  } svfb_in_t;

  // Output word: one byte of a frame
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stop_after;
    logic [1:0] target_display;
    logic       last;
  } svfb_out_t;

  // Classified request handed from the front end to the byte sequencer
  typedef struct packed {
    logic       action;
    logic       neg;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [3:0] tenths;
    logic [1:0] disp;
  } svfb_req_t;

  localparam logic       ACT_SHOW  = 1'b0;
  localparam logic       ACT_CLEAR = 1'b1;

  localparam logic [1:0] DISP_A = 2'd1;
  localparam logic [1:0] DISP_B = 2'd2;

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_CTRL  = 8'h88;
  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  // Index of the final byte of each kind of run
  localparam logic [3:0] SHOW_LAST  = 4'd6;
  localparam logic [3:0] CLEAR_LAST = 4'd9;

  // floor(m / 1000) == (m * RECIP_1000) >> 25 for m < 59999
  localparam logic [15:0] RECIP_1000 = 16'd33555;
  // floor(r / 100) == (r * 41) >> 12 for r < 1000
  localparam logic [15:0] RECIP_100  = 16'd41;
  // floor(r / 10) == (r * 205) >> 11 for r < 100
  localparam logic [14:0] RECIP_10   = 15'd205;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h6f;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

/* src/seven_segment_value_frame_builder_unit.sv */
// Top level of the seven-segment value frame builder.
`timescale 1ns / 1ps

// Turns show-value and clear requests for one of two four-digit displays into
// the byte words a two-wire display driver chip expects, one output word per
// byte, each with its stop flag, target display and an end-of-run mark. A show
// request yields seven words (data command, address, sign, tens, ones with
// decimal point, tenths, display control); a clear request yields ten (data
// command, address, seven blank bytes, display control). A request whose
// display_select is neither 1 nor 2 is dropped and yields no words. Requests
// are taken on any cycle where full is low; the front end splits the value into
// digits in a six-stage pipeline and parks the result in a QUEUE_DEPTH-entry
// queue. The sequencer then emits one word per cycle while pop keeps up; the
// words of back-to-back requests follow with no gap. A request passes the six
// front-end stages, the queue, the sequencer's request register and the output
// register. The brightness register (reset 3) is sampled when the control byte
// is built; write it only while the block is idle.

module seven_segment_value_frame_builder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  svfb_pkg::svfb_in_t  in_word,
  output logic                empty,
  input  logic                pop,
  output svfb_pkg::svfb_out_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_data
);
  import svfb_pkg::*;

  logic       [2:0] brightness;
  svfb_req_t        fq_data, qb_data;
  logic             fq_push, fq_full;
  logic             qb_pop, qb_empty;

  // Hold the brightness level; it feeds the display-control byte directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd3;
    end else if (cfg_we) begin
      brightness <= cfg_data;
    end
  end

  // Front end: classify, drop bad targets, extract digits.
  svfb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_full  (fq_full),
    .q_push  (fq_push),
    .q_data  (fq_data)
  );

  // Decouple digit extraction from byte emission.
  svfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (fq_full),
    .pop   (qb_pop),
    .rdata (qb_data),
    .empty (qb_empty)
  );

  // Back end: advance through the run, one word per cycle while pop keeps up.
  svfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .brightness (brightness),
    .q_empty    (qb_empty),
    .q_data     (qb_data),
    .q_pop      (qb_pop),
    .empty      (empty),
    .pop        (pop),
    .out_word   (out_word)
  );

endmodule

/* src/svfb_front.sv */
// Front end: accepts requests, drops those with no display, splits the value into digits.
`timescale 1ns / 1ps

module svfb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  svfb_pkg::svfb_in_t  in_word,
  input  logic                q_full,
  output logic                q_push,
  output svfb_pkg::svfb_req_t q_data
);
  import svfb_pkg::*;

  logic en;

  // stage 1: sign and magnitude
  logic        v1, act1, neg1;
  logic [1:0]  disp1;
  logic [15:0] mag1;
  // stage 2: thousands quotient
  logic        v2, act2, neg2;
  logic [1:0]  disp2;
  logic [15:0] mag2;
  logic [5:0]  q2;
  // stage 3: magnitude mod 1000
  logic        v3, act3, neg3;
  logic [1:0]  disp3;
  logic [9:0]  r3;
  // stage 4: tens digit
  logic        v4, act4, neg4;
  logic [1:0]  disp4;
  logic [9:0]  r4;
  logic [3:0]  tens4;
  // stage 5: remainder below 100
  logic        v5, act5, neg5;
  logic [1:0]  disp5;
  logic [3:0]  tens5;
  logic [6:0]  rem5;
  // stage 6: ones digit
  logic        v6, act6, neg6;
  logic [1:0]  disp6;
  logic [3:0]  tens6, ones6;
  logic [6:0]  rem6;

  logic        disp_ok;
  logic [15:0] mag_in;
  logic [31:0] prod1;
  logic [15:0] qk2, diff2;
  logic [15:0] p3;
  logic [9:0]  diff4;
  logic [14:0] p5;
  logic [6:0]  diff6;

  assign full = v6 & q_full;
  assign en   = ~full;

  assign disp_ok = (in_word.display_select == DISP_A) || (in_word.display_select == DISP_B);
  assign mag_in  = in_word.value_tenths[15] ? 16'(~in_word.value_tenths + 16'sd1)
                                            : 16'(in_word.value_tenths);

  assign prod1 = 32'(mag1) * 32'(RECIP_1000);
  assign qk2   = 16'(q2) * 16'd1000;
  assign diff2 = mag2 - qk2;
  assign p3    = 16'(r3) * RECIP_100;
  assign diff4 = r4 - 10'(tens4) * 10'd100;
  assign p5    = 15'(rem5) * RECIP_10;
  assign diff6 = rem6 - 7'(ones6) * 7'd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= push & disp_ok;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1  <= in_word.action;
      neg1  <= in_word.value_tenths[15];
      disp1 <= in_word.display_select;
      mag1  <= mag_in;

      act2  <= act1;
      neg2  <= neg1;
      disp2 <= disp1;
      mag2  <= mag1;
      q2    <= prod1[30:25];

      act3  <= act2;
      neg3  <= neg2;
      disp3 <= disp2;
      r3    <= diff2[9:0];

      act4  <= act3;
      neg4  <= neg3;
      disp4 <= disp3;
      r4    <= r3;
      tens4 <= p3[15:12];

      act5  <= act4;
      neg5  <= neg4;
      disp5 <= disp4;
      tens5 <= tens4;
      rem5  <= diff4[6:0];

      act6  <= act5;
      neg6  <= neg5;
      disp6 <= disp5;
      tens6 <= tens5;
      rem6  <= rem5;
      ones6 <= p5[14:11];
    end
  end

  assign q_push = v6 & ~q_full;

  always_comb begin
    q_data.action = act6;
    q_data.neg    = neg6;
    q_data.tens   = tens6;
    q_data.ones   = ones6;
    q_data.tenths = diff6[3:0];
    q_data.disp   = disp6;
  end

endmodule

/* src/svfb_queue.sv */
// Short request queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module svfb_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  svfb_pkg::svfb_req_t wdata,
  output logic                full,
  input  logic                pop,
  output svfb_pkg::svfb_req_t rdata,
  output logic                empty
);
  import svfb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  svfb_req_t         slots [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* src/svfb_back.sv */
// Back end: walks one request through its run of bytes into the output register.
`timescale 1ns / 1ps

module svfb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          brightness,
  input  logic                q_empty,
  input  svfb_pkg::svfb_req_t q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output svfb_pkg::svfb_out_t out_word
);
  import svfb_pkg::*;

  svfb_req_t  cur;
  logic       cur_valid;
  logic [3:0] idx;
  logic       out_valid;
  logic       adv, last_b;
  svfb_out_t  gen;

  assign empty  = ~out_valid;
  assign adv    = cur_valid & (~out_valid | pop);
  assign last_b = (cur.action == ACT_CLEAR) ? (idx == CLEAR_LAST) : (idx == SHOW_LAST);
  assign q_pop  = ~q_empty & (~cur_valid | (adv & last_b));

  always_comb begin
    gen.data_byte      = SEG_BLANK;
    gen.stop_after     = 1'b0;
    gen.target_display = cur.disp;
    gen.last           = last_b;
    if (last_b) begin
      gen.data_byte  = CMD_CTRL | {5'd0, brightness};
      gen.stop_after = 1'b1;
    end else begin
      unique case (idx)
        4'd0: begin
          gen.data_byte  = CMD_DATA;
          gen.stop_after = 1'b1;
        end
        4'd1: gen.data_byte = CMD_ADDR;
        4'd2: begin
          if (cur.action == ACT_SHOW) begin
            gen.data_byte = cur.neg ? SEG_MINUS : SEG_BLANK;
          end
        end
        4'd3: begin
          if (cur.action == ACT_SHOW) begin
            gen.data_byte = seg_of(cur.tens);
          end
        end
        4'd4: begin
          if (cur.action == ACT_SHOW) begin
            gen.data_byte = seg_of(cur.ones) | SEG_DP;
          end
        end
        4'd5: begin
          if (cur.action == ACT_SHOW) begin
            gen.data_byte  = seg_of(cur.tenths);
            gen.stop_after = 1'b1;
          end
        end
        4'd8: gen.stop_after = 1'b1;
        default: gen.data_byte = SEG_BLANK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (adv) begin
        if (last_b) begin
          cur_valid <= 1'b0;
        end
        idx <= idx + 4'd1;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (adv) begin
      out_word <= gen;
    end
  end

endmodule
